@@ src/sla_pkg.sv @@
package sla_pkg;

    // line store geometry
    localparam int LINE_DEPTH  = 64;
    localparam int STORE_SLOTS = LINE_DEPTH - 1;
    localparam int LEN_W       = 6;
    localparam int CHAR_W      = 7;

    // byte codes
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;

    // command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        CMD_WRITE,
        CMD_EMIT
    } cmd_op_t;

    // one request from the front to the back
    typedef struct packed {
        cmd_op_t             op;
        logic [LEN_W-1:0]    len_addr;
        logic [CHAR_W-1:0]   ch;
    } cmd_t;

    // queue handshake toward a consumer
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_out_t;

endpackage

@@ src/sla_front.sv @@
module sla_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                q_full,
    output logic                q_push,
    output sla_pkg::cmd_t       q_cmd
);

    logic [sla_pkg::LEN_W-1:0] fill_reg;
    logic [sla_pkg::LEN_W-1:0] fill_next;
    logic                      nl_reg;
    logic                      nl_next;
    logic                      accept;
    logic                      is_nl;
    logic                      is_print;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign is_nl    = (rx_byte == sla_pkg::CH_LF) || (rx_byte == sla_pkg::CH_CR);
    assign is_print = (rx_byte >= sla_pkg::PRINT_LOW) && (rx_byte <= sla_pkg::PRINT_HIGH);

    // classify the byte into a store write, a line emit or nothing
    always_comb
    begin
        fill_next       = fill_reg;
        nl_next         = nl_reg;
        q_push          = 1'b0;
        q_cmd.op        = sla_pkg::CMD_WRITE;
        q_cmd.len_addr  = fill_reg;
        q_cmd.ch        = rx_byte[sla_pkg::CHAR_W-1:0];
        if (accept)
        begin
            if (is_nl)
            begin
                if (!nl_reg && (fill_reg != '0))
                begin
                    q_push    = 1'b1;
                    q_cmd.op  = sla_pkg::CMD_EMIT;
                    fill_next = '0;
                end
                nl_next = 1'b1;
            end
            else if (is_print)
            begin
                if (fill_reg < sla_pkg::LEN_W'(sla_pkg::STORE_SLOTS))
                begin
                    q_push    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    fill_next = '0;
                end
                nl_next = 1'b0;
            end
            else
            begin
                nl_next = 1'b0;
            end
        end
    end

    // fill count and newline flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            nl_reg   <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            nl_reg   <= nl_next;
        end
    end

endmodule

@@ src/sla_cmd_queue.sv @@
module sla_cmd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sla_pkg::cmd_t          push_cmd,
    output logic                   full,
    input  logic                   pop,
    output sla_pkg::queue_out_t    head
);

    sla_pkg::cmd_t                 slot_reg [sla_pkg::QUEUE_DEPTH];
    logic [sla_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sla_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [sla_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sla_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [sla_pkg::QPTR_W:0]      count_reg;
    logic [sla_pkg::QPTR_W:0]      count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (count_reg == (sla_pkg::QPTR_W+1)'(sla_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/sla_back.sv @@
module sla_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sla_pkg::queue_out_t         head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sla_pkg::CHAR_W-1:0]  line_char,
    output logic [sla_pkg::LEN_W-1:0]   line_length,
    output logic                        last_char
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_OUT
    } back_state_t;

    back_state_t                 state_reg;
    back_state_t                 state_next;
    logic [sla_pkg::LEN_W-1:0]   len_reg;
    logic [sla_pkg::LEN_W-1:0]   len_next;
    logic [sla_pkg::LEN_W-1:0]   idx_reg;
    logic [sla_pkg::LEN_W-1:0]   idx_next;
    logic                        last_reg;
    logic                        last_next;
    logic                        mem_we;
    logic                        mem_re;
    logic [sla_pkg::CHAR_W-1:0]  rd_data_reg;
    logic [sla_pkg::CHAR_W-1:0]  line_mem [sla_pkg::STORE_SLOTS];

    assign out_valid   = (state_reg == B_OUT);
    assign line_char   = rd_data_reg;
    assign line_length = len_reg;
    assign last_char   = last_reg;

    // sequencer: store writes, then read out one character per pass
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.cmd.op == sla_pkg::CMD_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        len_next   = head.cmd.len_addr;
                        idx_next   = '0;
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                mem_re     = 1'b1;
                last_next  = (({1'b0, idx_reg} + 1'b1) == {1'b0, len_reg});
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            len_reg   <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    // line store, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[head.cmd.len_addr] <= head.cmd.ch;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_mem[idx_reg];
        end
    end

endmodule

@@ src/serial_line_assembler.sv @@
// serial_line_assembler: builds text lines from a stream of received bytes.
// Input channel in_valid / in_ready carries rx_byte. Printable bytes are
// stored; CR or LF ends a non-empty line, repeated CR/LF are skipped, a
// printable byte on a full store drops the partial line and that byte.
// Output channel out_valid / out_ready carries one character per request
// (line_char), with line_length and last_char marking the final character.
// The input takes a new byte whenever the queue is not full; a four-entry
// command queue sits between the classifier and the line store sequencer.
// The sequencer writes each stored character from the queue, and for each
// emitted character reads the memory, then shows it from the output register;
// each line starts its read-out with the emit command taken from the queue.
// After the ending CR/LF, the emit command passes through the queue, B_IDLE
// and B_READ before the first character appears in B_OUT.
// When the receiver stalls, the current character holds on the output,
// the queue fills and then in_ready drops until space frees up.
// Reset clears the fill count, the newline flag, the queue and the
// sequencer; the line store holds no reset value and needs no clearing.
module serial_line_assembler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sla_pkg::CHAR_W-1:0]  line_char,
    output logic [sla_pkg::LEN_W-1:0]   line_length,
    output logic                        last_char
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    sla_pkg::cmd_t        q_cmd;
    sla_pkg::queue_out_t  q_head;

    // byte classifier
    sla_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // command queue
    sla_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    // line store and read-out
    sla_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .line_char   (line_char),
        .line_length (line_length),
        .last_char   (last_char)
    );

endmodule

@@ sim/tb_serial_line_assembler.sv @@
`timescale 1ns / 1ps

module tb_serial_line_assembler;

    localparam int HALF_PERIOD = 6;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SHOW_LIMIT  = 10;
    localparam int TAIL_CYCLES = 40;

    // one character of a completed line as it should leave the block
    typedef struct {
        logic [sla_pkg::CHAR_W-1:0] ch;
        logic [sla_pkg::LEN_W-1:0]  len;
        logic                       last;
    } line_char_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [7:0]                 rx_byte = 8'd0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [sla_pkg::CHAR_W-1:0] line_char;
    logic [sla_pkg::LEN_W-1:0]  line_length;
    logic                       last_char;

    // line builder shadow state
    logic [sla_pkg::CHAR_W-1:0] held_chars [0:sla_pkg::STORE_SLOTS-1];
    int unsigned       held_count = 0;
    bit                after_newline = 1'b0;

    line_char_t        pending_chars [$];
    int                fail_count = 0;
    int                shown_count = 0;
    int                byte_count = 0;
    int                idle_cycles = 0;
    int                stall_left = 0;
    bit                idle_on = 1'b1;

    serial_line_assembler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .line_char   (line_char),
        .line_length (line_length),
        .last_char   (last_char)
    );

    always #HALF_PERIOD clk = ~clk;

    // shadow of the line builder: update state, queue the emitted characters
    function automatic void build_line(input logic [7:0] b);
        line_char_t c;
        if (b == sla_pkg::CH_LF || b == sla_pkg::CH_CR)
        begin
            if (!after_newline && held_count > 0)
            begin
                for (int k = 0; k < held_count; k++)
                begin
                    c.ch   = held_chars[k];
                    c.len  = sla_pkg::LEN_W'(held_count);
                    c.last = (k + 1 == held_count);
                    pending_chars.push_back(c);
                end
                held_count = 0;
            end
            after_newline = 1'b1;
        end
        else if (b >= sla_pkg::PRINT_LOW && b <= sla_pkg::PRINT_HIGH)
        begin
            // a printable byte on a full store drops the line and itself
            if (held_count < sla_pkg::STORE_SLOTS)
            begin
                held_chars[held_count] = b[sla_pkg::CHAR_W-1:0];
                held_count++;
            end
            else
                held_count = 0;
            after_newline = 1'b0;
        end
        else
            after_newline = 1'b0;
    endfunction

    // offer one byte, optionally after a short gap, and wait until it is accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        build_line(b);
        byte_count++;
    endtask

    function automatic logic [7:0] printable_byte();
        return 8'($urandom_range(sla_pkg::PRINT_LOW, sla_pkg::PRINT_HIGH));
    endfunction

    // control bytes other than CR/LF, or bytes 127..255
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0)
        begin
            b = 8'($urandom_range(0, 31));
            if (b == sla_pkg::CH_LF || b == sla_pkg::CH_CR)
                b = 8'd0;
        end
        else
            b = 8'($urandom_range(127, 255));
        return b;
    endfunction

    // one line with random content, an optional terminator and some noise
    task automatic send_random_line();
        int len;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = $urandom_range(sla_pkg::STORE_SLOTS - 2, sla_pkg::STORE_SLOTS + 2);
        else if (pick == 1)
            len = 0;
        else
            len = $urandom_range(1, 16);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_byte(noise_byte());
            send_byte(printable_byte());
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: send_byte(sla_pkg::CH_CR);
            3, 4, 5: send_byte(sla_pkg::CH_LF);
            6:
            begin
                send_byte(sla_pkg::CH_CR);
                send_byte(sla_pkg::CH_LF);
            end
            7:
            begin
                send_byte(sla_pkg::CH_LF);
                send_byte(sla_pkg::CH_CR);
                send_byte(sla_pkg::CH_LF);
            end
            8:
            begin
                // noise right after a line end clears the newline flag
                send_byte(sla_pkg::CH_LF);
                send_byte(noise_byte());
                send_byte(sla_pkg::CH_CR);
            end
            default: ;  // no terminator, the next line runs on
        endcase
    endtask

    // short lines covering the byte classes and the newline cases
    task automatic test_directed();
        send_byte(8'd72);           // single CR ends a line
        send_byte(8'd73);
        send_byte(sla_pkg::CH_CR);
        send_byte(sla_pkg::CH_LF);  // CR LF pair ends one line only
        send_byte(sla_pkg::CH_LF);  // empty line after newline
        send_byte(sla_pkg::PRINT_LOW);   // lowest and highest printable
        send_byte(sla_pkg::PRINT_HIGH);
        send_byte(8'd0);            // dropped bytes stay out of the line
        send_byte(8'd31);
        send_byte(8'd127);
        send_byte(8'd255);
        send_byte(sla_pkg::CH_LF);
        send_byte(sla_pkg::CH_CR);  // LF CR pair
        send_byte(8'd1);            // clears the flag, store still empty
        send_byte(sla_pkg::CH_CR);  // empty line with flag clear
        send_byte(8'd65);           // one-character line
        send_byte(sla_pkg::CH_LF);
        send_byte(8'd128);
        send_byte(8'd90);
        send_byte(sla_pkg::CH_CR);
    endtask

    // a line of full length, then an overflow that discards the line
    task automatic test_store_full();
        for (int k = 0; k < sla_pkg::STORE_SLOTS; k++)
            send_byte(printable_byte());
        send_byte(sla_pkg::CH_LF);
        for (int k = 0; k <= sla_pkg::STORE_SLOTS; k++)
            send_byte(printable_byte());
        send_byte(sla_pkg::CH_CR);  // store empty after the overflow
        send_byte(8'd66);
        send_byte(8'd67);
        send_byte(sla_pkg::CH_LF);
    endtask

    task automatic test_random_lines(input int target);
        while (byte_count < target)
            send_random_line();
    endtask

    // hold the sender until every queued character has come out
    task automatic test_pause_drain();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    // receiver side with random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    // compare each accepted character with the oldest expected one
    always @(posedge clk)
    begin
        line_char_t exp_c;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                fail_count++;
                if (shown_count < SHOW_LIMIT)
                begin
                    shown_count++;
                    $display("unexpected char %0d len %0d last %0d",
                             line_char, line_length, last_char);
                end
            end
            else
            begin
                exp_c = pending_chars.pop_front();
                if (line_char !== exp_c.ch || line_length !== exp_c.len ||
                    last_char !== exp_c.last)
                begin
                    fail_count++;
                    if (shown_count < SHOW_LIMIT)
                    begin
                        shown_count++;
                        $display("mismatch: char %0d/%0d len %0d/%0d last %0d/%0d",
                                 exp_c.ch, line_char, exp_c.len, line_length,
                                 exp_c.last, last_char);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_store_full();
        test_random_lines(200);
        test_pause_drain();
        idle_on = 1'b0;
        test_random_lines(250);

        // drain and let the block settle
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_chars.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
